// ===== rtl/core/pstd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstd_pkg
// Shared types, constants and helpers of the planar sprite tile decoder.
// ----------------------------------------------------------------------------
package pstd_pkg;

   // tile geometry
   localparam int TILE_BYTES  = 128;
   localparam int ADDR_W      = $clog2(TILE_BYTES);
   localparam int BYTE_W      = 8;
   localparam int ROW_W       = 4;
   localparam int PIXELS_W    = 64;
   localparam int HALF_W      = PIXELS_W / 2;
   localparam int STEP_W      = 3;
   localparam int SHIFT_W     = $clog2(PIXELS_W);

   localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(TILE_BYTES - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = '1;
   localparam logic [STEP_W-1:0] LAST_STEP = '1;

   // plane byte order codes
   localparam logic MODE_CART = 1'b0;
   localparam logic MODE_CD   = 1'b1;

   // control of one fetch step, aligned with the ram read data
   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      logic       half;
      logic [1:0] plane;
   } pstd_step_type;

   // put bit k of a plane byte at bit 4k of an 8-pixel half row
   function automatic logic [HALF_W-1:0] spread_plane(input logic [BYTE_W-1:0] plane_byte);
      logic [HALF_W-1:0] spread;
      spread = '0;
      for (int k = 0; k < BYTE_W; k++) begin
         spread[4*k] = plane_byte[k];
      end
      return spread;
   endfunction

endpackage

// ===== rtl/core/planar_sprite_tile_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_sprite_tile_decoder_unit
// Planar to chunky decoder for one 16x16 4bpp sprite tile.
// ----------------------------------------------------------------------------
// The block takes 128 tile bytes, one per cycle, into a 128 x 8 ram, then
// emits sixteen rows of 16 chunky 4-bit pixels, top row first. Each row is
// built by one shared scatter unit that reads the ram once per cycle while
// fetching, eight plane bytes per row. The finished row is held in an
// output register until taken; the next row starts fetching the cycle
// after that take. Tile loading and row emission do not overlap, and the
// single ram read port limits how fast rows are built. The input is
// stalled while rows are being emitted. The mode register is sampled with
// the last byte of a tile.
module planar_sprite_tile_decoder_unit (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write_enable,
   input  logic                                csr_write_data,
   // byte input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pstd_pkg::BYTE_W-1:0]         req_tile_byte,
   // row output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pstd_pkg::ROW_W-1:0]          rsp_row_index,
   output logic [pstd_pkg::PIXELS_W-1:0]       rsp_row_pixels,
   output logic                                rsp_last_row
);
   import pstd_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FETCH,
      ST_HOLD
   } state_type;

   state_type           state_ff, state_in;
   logic                mode_ff, mode_in;
   logic                mode_lat_ff, mode_lat_in;
   logic [ADDR_W-1:0]   byte_count_ff, byte_count_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   pstd_step_type       ctl_ff, ctl_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [PIXELS_W-1:0] rsp_pixels_ff, rsp_pixels_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_take;
   logic                rsp_take;
   logic [ADDR_W-1:0]   rd_addr;
   logic [BYTE_W-1:0]   rd_data;
   logic [PIXELS_W-1:0] row_next;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   // quadrant {~half, lower}, then row within quadrant, then plane byte
   assign rd_addr = {~step_ff[2], row_ff[3], row_ff[2:0], step_ff[1:0]};

   pstd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TILE_BYTES)
   ) u_tile_ram (
      .clock   (clock),
      .wr_en   (req_take),
      .wr_addr (byte_count_ff),
      .wr_data (req_tile_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pstd_row_unit u_row_unit (
      .clock      (clock),
      .step       (ctl_ff),
      .plane_byte (rd_data),
      .row_next   (row_next)
   );

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      mode_in       = csr_write_enable ? csr_write_data : mode_ff;
      mode_lat_in   = mode_lat_ff;
      byte_count_in = byte_count_ff;
      row_in        = row_ff;
      step_in       = step_ff;
      ctl_in        = '0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_pixels_in = rsp_pixels_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               byte_count_in = byte_count_ff + 1'b1;
               if (byte_count_ff == LAST_BYTE) begin
                  mode_lat_in = mode_in;
                  row_in      = '0;
                  step_in     = '0;
                  state_in    = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            // issue one ram read, its control follows with the data
            ctl_in.valid = 1'b1;
            ctl_in.first = (step_ff == '0);
            ctl_in.last  = (step_ff == LAST_STEP);
            ctl_in.half  = step_ff[2];
            ctl_in.plane = step_ff[1:0] ^ {1'b0, (mode_lat_ff == MODE_CD)};
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_take) begin
               step_in = '0;
               if (row_ff == LAST_ROW) begin
                  state_in = ST_LOAD;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // output register: loads when the row word is complete
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl_ff.valid && ctl_ff.last) begin
         rsp_valid_in  = 1'b1;
         rsp_index_in  = row_ff;
         rsp_pixels_in = row_next;
         rsp_last_in   = (row_ff == LAST_ROW);
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         mode_ff       <= MODE_CART;
         mode_lat_ff   <= MODE_CART;
         byte_count_ff <= '0;
         row_ff        <= '0;
         step_ff       <= '0;
         ctl_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         mode_lat_ff   <= mode_lat_in;
         byte_count_ff <= byte_count_in;
         row_ff        <= row_in;
         step_ff       <= step_in;
         ctl_ff        <= ctl_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_index_ff  <= rsp_index_in;
      rsp_pixels_ff <= rsp_pixels_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall      = (state_ff != ST_LOAD);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_index  = rsp_index_ff;
   assign rsp_row_pixels = rsp_pixels_ff;
   assign rsp_last_row   = rsp_last_ff;

`ifndef SYNTHESIS
   // no byte is taken while a row is still waiting
   a_no_load_during_rows: assert property (@(posedge clock) disable iff (reset)
      !(req_take && rsp_valid_ff))
      else $error("byte accepted while a row is pending");

   // the last byte of a tile starts emission
   a_last_byte_starts_rows: assert property (@(posedge clock) disable iff (reset)
      (req_take && byte_count_ff == LAST_BYTE) |=> (req_stall && !rsp_valid_ff))
      else $error("tile completion did not start row emission");

   // taking the last row reopens the input
   a_last_row_reopens: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last_ff) |=> (!req_stall && byte_count_ff == '0))
      else $error("input not reopened after last row");

   // taking an earlier row starts fetching the next one
   a_next_row_fetch: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_last_ff) |=> (state_ff == ST_FETCH && !rsp_valid_ff))
      else $error("next row fetch did not start");
`endif

endmodule

// ===== rtl/core/pstd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstd_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module pstd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pstd_row_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstd_row_unit
// Shared scatter unit: merges one plane byte per cycle, on valid steps, into the row word.
// ----------------------------------------------------------------------------
module pstd_row_unit (
   input  logic                                clock,
   input  pstd_pkg::pstd_step_type             step,
   input  logic [pstd_pkg::BYTE_W-1:0]         plane_byte,
   output logic [pstd_pkg::PIXELS_W-1:0]       row_next
);
   import pstd_pkg::*;

   logic [PIXELS_W-1:0] row_ff;
   logic [PIXELS_W-1:0] row_in;
   logic [SHIFT_W-1:0]  shift_amt;
   logic [PIXELS_W-1:0] contrib;

   // bit k lands on column k of the selected half, at the plane's bit
   assign shift_amt = {step.half, (SHIFT_W - 3)'(0), step.plane};
   assign contrib   = {{HALF_W{1'b0}}, spread_plane(plane_byte)} << shift_amt;

   // first step of a row starts a fresh word
   always_comb begin
      row_in = row_ff;
      if (step.valid) begin
         row_in = step.first ? contrib : (row_ff | contrib);
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign row_next = row_in;

endmodule

// ===== dv/pstd_tile_row_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstd_tile_row_checker
// Watches the byte, row and register ports of the sprite tile decoder,
// keeps its own copy of the tile store and plane order, works out the
// sixteen chunky rows of every completed tile and compares each row the
// block hands out with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module pstd_tile_row_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [pstd_pkg::BYTE_W-1:0]   req_tile_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [pstd_pkg::ROW_W-1:0]    rsp_row_index,
   input  logic [pstd_pkg::PIXELS_W-1:0] rsp_row_pixels,
   input  logic                          rsp_last_row,
   output int                            fail_count,
   output int                            rows_pending,
   output int                            rows_checked,
   output int                            tiles_decoded
);
   import pstd_pkg::*;

   // first byte of each 8x8 quadrant in source order
   localparam int UL_BASE = 64;
   localparam int UR_BASE = 0;
   localparam int LL_BASE = 96;
   localparam int LR_BASE = 32;
   localparam int QUAD_ROWS = 8;
   localparam int TILE_ROWS = 16;

   typedef struct packed {
      logic [ROW_W-1:0]    row;
      logic [PIXELS_W-1:0] pixels;
      logic                last;
   } tile_row_type;

   logic [BYTE_W-1:0] tile_bytes [TILE_BYTES];
   logic [ADDR_W-1:0] fill_count;
   logic              plane_order;
   tile_row_type      expected_rows [$];

   task automatic report_mismatch(input string what);
      $display("%0t ns: row mismatch: %s", $time, what);
      fail_count++;
   endtask

   // sixteen rows of the stored tile under the current plane order
   function automatic void queue_tile_rows();
      tile_row_type row_item;
      int           left_base;
      int           right_base;
      int           base;
      int           plane_sel;
      for (int r = 0; r < TILE_ROWS; r++) begin
         if (r < QUAD_ROWS) begin
            left_base  = UL_BASE + 4 * r;
            right_base = UR_BASE + 4 * r;
         end else begin
            left_base  = LL_BASE + 4 * (r - QUAD_ROWS);
            right_base = LR_BASE + 4 * (r - QUAD_ROWS);
         end
         row_item.row    = ROW_W'(r);
         row_item.last   = (ROW_W'(r) == LAST_ROW);
         row_item.pixels = '0;
         for (int c = 0; c < 2 * QUAD_ROWS; c++) begin
            base = (c < QUAD_ROWS) ? left_base : right_base;
            for (int j = 0; j < 4; j++) begin
               // cd order swaps the plane bytes pairwise
               plane_sel = (plane_order == MODE_CD) ? (j ^ 1) : j;
               row_item.pixels[4 * c + j] = tile_bytes[base + plane_sel][c % QUAD_ROWS];
            end
         end
         expected_rows.push_back(row_item);
      end
   endfunction

   always @(posedge clock) begin
      tile_row_type want;
      if (reset) begin
         fill_count  = '0;
         plane_order = MODE_CART;
         expected_rows.delete();
      end else begin
         // register write
         if (csr_write_enable) begin
            plane_order = csr_write_data;
         end
         // row taken from the block
         if (rsp_valid && !rsp_stall) begin
            rows_checked++;
            if (expected_rows.size() == 0) begin
               report_mismatch($sformatf("row %0d with no tile pending", rsp_row_index));
            end else begin
               want = expected_rows.pop_front();
               if (rsp_row_index !== want.row) begin
                  report_mismatch($sformatf("row_index %0d, expected %0d",
                                            rsp_row_index, want.row));
               end
               if (rsp_row_pixels !== want.pixels) begin
                  report_mismatch($sformatf("row %0d pixels %h, expected %h",
                                            want.row, rsp_row_pixels, want.pixels));
               end
               if (rsp_last_row !== want.last) begin
                  report_mismatch($sformatf("row %0d last_row %b, expected %b",
                                            want.row, rsp_last_row, want.last));
               end
            end
         end
         // byte taken into the tile store
         if (req_valid && !req_stall) begin
            tile_bytes[fill_count] = req_tile_byte;
            if (fill_count == LAST_BYTE) begin
               queue_tile_rows();
               tiles_decoded++;
            end
            fill_count = fill_count + 1'b1;
         end
      end
      rows_pending <= expected_rows.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the planar sprite tile decoder. Sends a patterned
// tile, then a random tile in cd order with no gaps, a tile whose order
// changes part way through and a partial tile at the end, with random gaps
// on both sides and one long output hold-off. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_top;
   import pstd_pkg::*;

   localparam int SETTLE_CYCLES   = 30;
   localparam int TAIL_CYCLES     = 40;
   localparam int HOLD_AFTER_ROWS = 36;
   localparam int HOLD_CYCLES     = 400;
   localparam int SPLIT_BYTES     = 60;
   localparam int PARTIAL_BYTES   = 36;

   logic                clock;
   logic                reset            = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic                csr_write_data   = 1'b0;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_tile_byte    = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [ROW_W-1:0]    rsp_row_index;
   logic [PIXELS_W-1:0] rsp_row_pixels;
   logic                rsp_last_row;
   logic                calm             = 1'b0;

   int fail_count;
   int rows_pending;
   int rows_checked;
   int tiles_decoded;
   int bytes_sent = 0;
   int rows_taken = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;

   planar_sprite_tile_decoder_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_tile_byte    (req_tile_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_index    (rsp_row_index),
      .rsp_row_pixels   (rsp_row_pixels),
      .rsp_last_row     (rsp_last_row)
   );

   pstd_tile_row_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_tile_byte    (req_tile_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_index    (rsp_row_index),
      .rsp_row_pixels   (rsp_row_pixels),
      .rsp_last_row     (rsp_last_row),
      .fail_count       (fail_count),
      .rows_pending     (rows_pending),
      .rows_checked     (rows_checked),
      .tiles_decoded    (tiles_decoded)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("[planar_sprite_tile_decoder_unit] ERROR");
      $finish;
   end

   // row receiver: random stalls, one long hold-off in the third tile
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rows_taken++;
         end
         if (!hold_done && rows_taken == HOLD_AFTER_ROWS) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 20);
         end
      end
   end

   // offer one byte, with a random gap first unless calm, and wait until it is taken
   task automatic send_tile_byte(input logic [BYTE_W-1:0] value);
      int gap;
      gap = 0;
      if (!calm) begin
         while ($urandom_range(0, 99) < 20) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_tile_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // let all rows drain and the block settle
   task automatic drain_rows();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_plane_order(input logic order);
      drain_rows();
      csr_write_enable <= 1'b1;
      csr_write_data   <= order;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [BYTE_W-1:0] pattern;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // patterned tile in cartridge order: zeros, ones and walking ones
      write_plane_order(MODE_CART);
      for (int i = 0; i < TILE_BYTES; i++) begin
         case (i % 10)
            0:       pattern = 8'h00;
            1:       pattern = 8'hFF;
            default: pattern = 8'h01 << (i % 10 - 2);
         endcase
         send_tile_byte(pattern);
      end

      // random tile in cd order without any gaps
      write_plane_order(MODE_CD);
      calm <= 1'b1;
      for (int i = 0; i < TILE_BYTES; i++) send_tile_byte(BYTE_W'($urandom_range(0, 255)));
      calm <= 1'b0;

      // order changed part way through a tile
      write_plane_order(MODE_CART);
      for (int i = 0; i < SPLIT_BYTES; i++) send_tile_byte(BYTE_W'($urandom_range(0, 255)));
      write_plane_order(MODE_CD);
      for (int i = SPLIT_BYTES; i < TILE_BYTES; i++) begin
         send_tile_byte(BYTE_W'($urandom_range(0, 255)));
      end

      // partial tile, offered while the receiver holds off
      for (int i = 0; i < PARTIAL_BYTES; i++) send_tile_byte(BYTE_W'($urandom_range(0, 255)));

      drain_rows();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d tile bytes, decoded %0d tiles, checked %0d rows in both plane orders",
               bytes_sent, tiles_decoded, rows_checked);
      $display("included a mid-tile order change, a partial last tile and a %0d-cycle hold-off",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("[planar_sprite_tile_decoder_unit] OK");
      end else begin
         $display("[planar_sprite_tile_decoder_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pstd_pkg.sv
rtl/core/pstd_ram.sv
rtl/core/pstd_row_unit.sv
rtl/core/planar_sprite_tile_decoder_unit.sv
dv/pstd_tile_row_checker.sv
dv/tb_top.sv
